@@ rtl/bspline_surface_knot_vector_defines.svh @@
// Assertion helpers for the knot vector block
`ifndef BSPLINE_SURFACE_KNOT_VECTOR_DEFINES_SVH
`define BSPLINE_SURFACE_KNOT_VECTOR_DEFINES_SVH

// same-cycle implication
`define BSKV_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BSKV_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/bskv_pkg.sv @@
`default_nettype none
package bskv_pkg;

   localparam int DEGREE          = 3;
   localparam int MAX_SIDE_POINTS = 16;
   localparam int STORE_DEPTH     = MAX_SIDE_POINTS * MAX_SIDE_POINTS;
   localparam int STORE_AW        = $clog2(STORE_DEPTH);

   localparam logic [16:0] KNOT_ONE = 17'h10000;
   localparam logic [3:0]  LAST_MIN = 4'(DEGREE);
   localparam logic [3:0]  LAST_MAX = 4'(MAX_SIDE_POINTS - 1);

   // register index codes
   localparam logic REG_U = 1'b0;
   localparam logic REG_V = 1'b1;

   // knot vector direction codes
   localparam logic DIR_U = 1'b0;
   localparam logic DIR_V = 1'b1;

endpackage
`default_nettype wire

@@ rtl/bspline_surface_knot_vector.sv @@
// Hartley-Judd knot vectors, cubic surface. Points load at one item per cycle.
// The final point starts a walk over the grid: each point distance uses one shared
// 32x32 multiplier, then a one-bit-per-cycle square root; each normalised knot and
// each averaged knot uses the shared restoring divider.
// Knots then leave one at a time, each held until rsp_tready is high; no item is
// taken meanwhile.
// Reset (synchronous): load counter cleared, both last indexes 3, no result pending.
`default_nettype none
`include "bspline_surface_knot_vector_defines.svh"
module bspline_surface_knot_vector
   import bskv_pkg::*;
(
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_tvalid,
   output logic              req_tready,
   input  wire  logic [95:0] req_tdata,   // coord_x, coord_y, coord_z
   output logic              rsp_tvalid,
   input  wire  logic        rsp_tready,
   output logic [23:0]       rsp_tdata,   // knot_index, knot_value, zero pad
   output logic              rsp_tuser,   // direction
   output logic              rsp_tlast,   // last_knot
   input  wire  logic        csr_psel,
   input  wire  logic        csr_penable,
   input  wire  logic        csr_pwrite,
   input  wire  logic [2:0]  csr_paddr,
   input  wire  logic [31:0] csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_DIR, ST_LINE, ST_RD, ST_GET, ST_SQ, ST_ADD, ST_RINIT,
      ST_ROOT, ST_DIST, ST_NORM, ST_DIV, ST_ACC, ST_EMIT, ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [8:0]  loaded_ff, loaded_in;
   logic [3:0]  u_last_ff, u_last_in, v_last_ff, v_last_in;
   logic        dir_ff, dir_in;
   logic [3:0]  n_ff, n_in, m_ff, m_in, line_ff, line_in, t_ff, t_in, seg_ff, seg_in;
   logic [STORE_AW-1:0] base_ff, base_in, addr_ff, addr_in;
   logic [95:0] prev_ff, prev_in, rd_data_ff;
   logic [95:0] store_mem [STORE_DEPTH];
   logic [31:0] mag_ff [3];
   logic [31:0] mag_in [3];
   logic [1:0]  comp_ff, comp_in;
   logic [63:0] prod_ff, prod_in;
   logic [65:0] sum_ff, sum_in;
   logic [63:0] rnum_ff, rnum_in, rres_ff, rres_in, rbit_ff, rbit_in;
   logic [4:0]  rcnt_ff, rcnt_in;
   logic [31:0] w0_ff, w0_in, w1_ff, w1_in;
   logic [37:0] cum_ff, cum_in;
   logic [37:0] cum_mem [MAX_SIDE_POINTS];
   logic [23:0] acc_mem [MAX_SIDE_POINTS];
   logic [38:0] drem_ff, drem_in;
   logic [16:0] dlo_ff, dlo_in, dq_ff, dq_in;
   logic [37:0] dden_ff, dden_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic        dret_ff, dret_in;
   logic [4:0]  k_ff, k_in;
   logic [16:0] knot_ff, knot_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        store_we, cum_we, acc_we;
   logic [3:0]  cum_wa;
   logic [37:0] cum_wd;
   logic [23:0] acc_wd;
   logic [3:0]  nu, nv;
   logic [8:0]  grid_count;
   logic [STORE_AW-1:0] stride;
   logic [31:0] mag_sel;
   logic [63:0] prod_w;
   logic [63:0] trial;
   logic [38:0] dr;
   logic [37:0] cum_next;
   logic [4:0]  n_ext;
   logic [32:0] diff  [3];
   logic [32:0] ndiff [3];

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_V) ? {28'b0, v_last_ff} : {28'b0, u_last_ff};
   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b0, knot_ff, k_ff};
   assign rsp_tuser  = dir_ff;
   assign n_ext      = {1'b0, n_ff};
   assign rsp_tlast  = (dir_ff == DIR_V) && (k_ff == n_ext + 5'd4);
   assign store_we   = req_tvalid && req_tready && !loaded_ff[8];

   always_comb begin
      nu = (u_last_ff < LAST_MIN) ? LAST_MIN : ((u_last_ff > LAST_MAX) ? LAST_MAX : u_last_ff);
      nv = (v_last_ff < LAST_MIN) ? LAST_MIN : ((v_last_ff > LAST_MAX) ? LAST_MAX : v_last_ff);
      grid_count = 9'(({5'b0, nu} + 10'd1) * ({5'b0, nv} + 10'd1));
      stride  = STORE_AW'({1'b0, nu} + 5'd1);
      mag_sel = mag_ff[comp_ff];
      prod_w  = mag_sel * mag_sel;
      trial   = rres_ff + rbit_ff;
      dr      = {drem_ff[37:0], dlo_ff[16]};
      cum_next = cum_ff + 38'(w1_ff) + 38'(w0_ff) + 38'(rres_ff[31:0]);
      for (int c = 0; c < 3; c++) begin
         diff[c]  = {rd_data_ff[32*c+31], rd_data_ff[32*c +: 32]}
                  - {prev_ff[32*c+31], prev_ff[32*c +: 32]};
         ndiff[c] = -diff[c];
         mag_in[c] = diff[c][32] ? ndiff[c][31:0] : diff[c][31:0];
      end
   end

   always_comb begin
      state_in = state_ff;   loaded_in = loaded_ff;
      u_last_in = u_last_ff; v_last_in = v_last_ff;
      dir_in = dir_ff; n_in = n_ff; m_in = m_ff; line_in = line_ff; t_in = t_ff;
      seg_in = seg_ff; base_in = base_ff; addr_in = addr_ff; prev_in = prev_ff;
      comp_in = comp_ff; prod_in = prod_ff; sum_in = sum_ff;
      rnum_in = rnum_ff; rres_in = rres_ff; rbit_in = rbit_ff; rcnt_in = rcnt_ff;
      w0_in = w0_ff; w1_in = w1_ff; cum_in = cum_ff;
      drem_in = drem_ff; dlo_in = dlo_ff; dq_in = dq_ff; dden_in = dden_ff;
      dcnt_in = dcnt_ff; dret_in = dret_ff;
      k_in = k_ff; knot_in = knot_ff; rsp_valid_in = rsp_valid_ff;
      cum_we = 1'b0; cum_wa = t_ff - 4'd3; cum_wd = cum_next;
      acc_we = 1'b0;
      acc_wd = ((line_ff == 4'd0) ? 24'd0 : acc_mem[seg_ff]) + {7'b0, dq_ff};

      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == REG_U) u_last_in = csr_pwdata[3:0];
         else                       v_last_in = csr_pwdata[3:0];
      end

      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               loaded_in = loaded_ff + 9'd1;
               if (loaded_in >= grid_count) begin
                  loaded_in = 9'd0;
                  dir_in    = DIR_U;
                  state_in  = ST_DIR;
               end
            end
         end
         ST_DIR: begin
            n_in = (dir_ff == DIR_V) ? nv : nu;
            m_in = (dir_ff == DIR_V) ? nu : nv;
            line_in = 4'd0; base_in = '0; k_in = 5'd0; seg_in = 4'd0;
            state_in = (n_in == LAST_MIN) ? ST_EMIT : ST_LINE;
         end
         ST_LINE: begin
            addr_in = base_ff; t_in = 4'd0; cum_in = 38'd0;
            state_in = ST_RD;
         end
         ST_RD: state_in = ST_GET;
         ST_GET: begin
            prev_in = rd_data_ff;
            if (t_ff == 4'd0) begin
               t_in = 4'd1;
               addr_in = addr_ff + ((dir_ff == DIR_V) ? stride : STORE_AW'(1));
               state_in = ST_RD;
            end else begin
               comp_in = 2'd0; sum_in = 66'd0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            prod_in = prod_w;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in = sum_ff + {2'b0, prod_ff};
            comp_in = comp_ff + 2'd1;
            state_in = (comp_ff == 2'd2) ? ST_RINIT : ST_SQ;
         end
         ST_RINIT: begin
            rnum_in = sum_ff[63:0]; rres_in = 64'd0;
            rbit_in = 64'h4000_0000_0000_0000; rcnt_in = 5'd0;
            if (sum_ff[65:64] != 2'd0) begin
               rres_in  = 64'h0000_0000_FFFF_FFFF;
               state_in = ST_DIST;
            end else begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (rnum_ff >= trial) begin
               rnum_in = rnum_ff - trial;
               rres_in = (rres_ff >> 1) + rbit_ff;
            end else begin
               rres_in = rres_ff >> 1;
            end
            rbit_in = rbit_ff >> 2;
            rcnt_in = rcnt_ff + 5'd1;
            if (rcnt_ff == 5'd31) state_in = ST_DIST;
         end
         ST_DIST: begin
            if (t_ff >= 4'd3) begin
               cum_we = 1'b1;
               cum_in = cum_next;
            end
            w1_in = w0_ff;
            w0_in = rres_ff[31:0];
            if (t_ff == n_ff) begin
               seg_in = 4'd0;
               state_in = ST_NORM;
            end else begin
               t_in = t_ff + 4'd1;
               addr_in = addr_ff + ((dir_ff == DIR_V) ? stride : STORE_AW'(1));
               state_in = ST_RD;
            end
         end
         ST_NORM: begin
            if (cum_ff == 38'd0) begin
               drem_in = 39'({4'b0, seg_ff} + 5'd1) >> 1;
               dlo_in  = {seg_ff[0] ^ 1'b1, 16'b0};
               dden_in = 38'(n_ff - 4'd2);
            end else begin
               drem_in = {2'b0, cum_mem[seg_ff][37:1]};
               dlo_in  = {cum_mem[seg_ff][0], 16'b0};
               dden_in = cum_ff;
            end
            dq_in = 17'd0; dcnt_in = 5'd0; dret_in = 1'b0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dr >= {1'b0, dden_ff}) begin
               drem_in = dr - {1'b0, dden_ff};
               dq_in   = {dq_ff[15:0], 1'b1};
            end else begin
               drem_in = dr;
               dq_in   = {dq_ff[15:0], 1'b0};
            end
            dlo_in  = {dlo_ff[15:0], 1'b0};
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd16) begin
               if (dret_ff) begin
                  knot_in = dq_in;
                  rsp_valid_in = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            acc_we = 1'b1;
            if (seg_ff == n_ff - 4'd4) begin
               if (line_ff == m_ff) begin
                  seg_in = 4'd0; k_in = 5'd0;
                  state_in = ST_EMIT;
               end else begin
                  line_in = line_ff + 4'd1;
                  base_in = base_ff + ((dir_ff == DIR_V) ? STORE_AW'(1) : stride);
                  state_in = ST_LINE;
               end
            end else begin
               seg_in = seg_ff + 4'd1;
               state_in = ST_NORM;
            end
         end
         ST_EMIT: begin
            if (k_ff <= 5'd3) begin
               knot_in = 17'd0; rsp_valid_in = 1'b1; state_in = ST_OUT;
            end else if (k_ff > n_ext) begin
               knot_in = KNOT_ONE; rsp_valid_in = 1'b1; state_in = ST_OUT;
            end else begin
               drem_in = {32'b0, acc_mem[seg_ff][23:17]};
               dlo_in  = acc_mem[seg_ff][16:0];
               dden_in = 38'({1'b0, m_ff} + 5'd1);
               dq_in = 17'd0; dcnt_in = 5'd0; dret_in = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (k_ff >= 5'd4 && k_ff <= n_ext) seg_in = seg_ff + 4'd1;
               k_in = k_ff + 5'd1;
               if (k_ff == n_ext + 5'd4) begin
                  if (dir_ff == DIR_V) begin
                     state_in = ST_LOAD;
                  end else begin
                     dir_in = DIR_V;
                     state_in = ST_DIR;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (store_we) store_mem[loaded_ff[STORE_AW-1:0]] <= req_tdata;
      rd_data_ff <= store_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (cum_we) cum_mem[cum_wa] <= cum_wd;
      if (acc_we) acc_mem[seg_ff] <= acc_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         loaded_ff    <= 9'd0;
         u_last_ff    <= LAST_MIN;
         v_last_ff    <= LAST_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         u_last_ff    <= u_last_in;
         v_last_ff    <= v_last_in;
         rsp_valid_ff <= rsp_valid_in;
         dir_ff <= dir_in; n_ff <= n_in; m_ff <= m_in; line_ff <= line_in; t_ff <= t_in;
         seg_ff <= seg_in; base_ff <= base_in; addr_ff <= addr_in; prev_ff <= prev_in;
         if (state_ff == ST_GET) begin
            mag_ff[0] <= mag_in[0];
            mag_ff[1] <= mag_in[1];
            mag_ff[2] <= mag_in[2];
         end
         comp_ff <= comp_in; prod_ff <= prod_in; sum_ff <= sum_in;
         rnum_ff <= rnum_in; rres_ff <= rres_in; rbit_ff <= rbit_in; rcnt_ff <= rcnt_in;
         w0_ff <= w0_in; w1_ff <= w1_in; cum_ff <= cum_in;
         drem_ff <= drem_in; dlo_ff <= dlo_in; dq_ff <= dq_in; dden_ff <= dden_in;
         dcnt_ff <= dcnt_in; dret_ff <= dret_in;
         k_ff <= k_in; knot_ff <= knot_in;
      end
   end

   `BSKV_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "item taken while result pending")
   `BSKV_ASSERT_IMPL(a_last_is_v, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser == DIR_V, "last knot not in v")
   `BSKV_ASSERT_IMPL(a_knot_range, clock, reset, rsp_tvalid, rsp_tdata[21:5] <= KNOT_ONE, "knot above one")
   `BSKV_ASSERT_NEXT(a_back_to_load, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "no return to loading")

endmodule
`default_nettype wire
